// File: rtl/i2curm_pkg.sv
`timescale 1ns / 1ps

package i2curm_pkg;

    typedef enum logic [3:0] {
        OP_START_WRITE = 4'd0,
        OP_START_READ  = 4'd1,
        OP_WRITE_BYTE  = 4'd2,
        OP_READ_BYTE   = 4'd3,
        OP_STOP        = 4'd4,
        OP_LOG_CHAR    = 4'd5,
        OP_SUM_BYTE    = 4'd6,
        OP_SUM_DONE    = 4'd7,
        OP_PAGE_READ   = 4'd8
    } op_t;

    // register map
    localparam logic [7:0] A_CMD   = 8'h03;
    localparam logic [7:0] A_STAGE = 8'h3c;
    localparam logic [7:0] A_LOG   = 8'h62;
    localparam logic [7:0] A_TRIG  = 8'h63;
    localparam logic [7:0] A_SOFF  = 8'h64;
    localparam logic [7:0] A_SLEN  = 8'h68;
    localparam logic [7:0] A_SUM   = 8'h6c;
    localparam logic [7:0] A_FOFF  = 8'h7c;
    localparam logic [7:0] A_PAGE  = 8'h80;

    localparam logic [7:0] STAGE_CODE = 8'h02;

    // command words that request a reset
    localparam logic [7:0] CMD_RST_A = 8'h02;
    localparam logic [7:0] CMD_RST_B = 8'h03;
    localparam logic [7:0] CMD_RST_C = 8'h07;

    typedef enum logic [1:0] {
        RD_LOCAL,
        RD_SUM,
        RD_LOG
    } rd_src_t;

endpackage

// File: rtl/i2curm_ram.sv
`timescale 1ns / 1ps

module i2curm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/i2curm_pgmod.sv
`timescale 1ns / 1ps

// rounds a 32-bit offset down to a multiple of DIVISOR, a power of two
module i2curm_pgmod #(
    parameter int DIVISOR = 128
) (
    input  logic [31:0] value,
    output logic [31:0] addr
);

    assign addr = value & ~32'(DIVISOR - 1);

endmodule

// File: rtl/i2c_upgrade_register_map_core.sv
// Pipeline: an accepted word and any memory read it starts are registered in stage 1; the
// result word then moves to the output register once that register is free or being taken.
// Throughput: one input word per cycle, stalled only by a full output register.
// Reset: asynchronous, active low; clears the control registers and valid bits and the valid
// bits of the page and checksum memories, not the pipeline data registers. The log memory
// reads as zero at or above its write pointer until the pointer first wraps. No clearing pass.
`timescale 1ns / 1ps

module i2c_upgrade_register_map_core #(
    parameter int PAGE_BYTES = 128,
    parameter int LOG_DEPTH  = 256,
    parameter int SUM_BYTES  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  operation,
    input  logic [7:0]  data_byte,
    input  logic [6:0]  side_index,
    input  logic [7:0]  flash_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        flush_request,
    output logic [31:0] flush_address,
    output logic        reset_request,
    output logic        checksum_pending,
    output logic [31:0] checksum_offset,
    output logic [31:0] checksum_length,
    output logic [7:0]  page_byte
);

    import i2curm_pkg::*;

    localparam int PAGE_AW  = $clog2(PAGE_BYTES);
    localparam int LOG_AW   = $clog2(LOG_DEPTH);
    localparam int SUM_AW   = $clog2(SUM_BYTES);
    localparam int PAGE_END = int'(A_PAGE) + PAGE_BYTES;
    localparam int SUM_END  = int'(A_SUM) + SUM_BYTES;

    function automatic logic [31:0] put_be(input logic [31:0] w, input logic [1:0] k,
                                           input logic [7:0] b);
        logic [31:0] r;
        r = w;
        case (k)
            2'd0:    r[31:24] = b;
            2'd1:    r[23:16] = b;
            2'd2:    r[15:8]  = b;
            default: r[7:0]   = b;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] get_be(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] r;
        case (k)
            2'd0:    r = w[31:24];
            2'd1:    r = w[23:16];
            2'd2:    r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

    // byte modulo LOG_DEPTH; quotient is below 16
    function automatic logic [LOG_AW-1:0] log_wrap(input logic [7:0] v);
        logic [11:0] r;
        r = {4'd0, v};
        for (int s = 3; s >= 0; s--)
        begin
            if (r >= (12'(LOG_DEPTH) << s))
            begin
                r = r - (12'(LOG_DEPTH) << s);
            end
        end
        return r[LOG_AW-1:0];
    endfunction

    function automatic logic [LOG_AW-1:0] log_inc(input logic [LOG_AW-1:0] p);
        logic [LOG_AW-1:0] r;
        if (p == LOG_AW'(LOG_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // architectural state
    logic [7:0]        reg_index_reg, reg_index_next;
    logic              idx_pend_reg, idx_pend_next;
    logic              flush_armed_reg, flush_armed_next;
    logic [31:0]       foff_reg, foff_next;
    logic [31:0]       sum_off_reg, sum_off_next;
    logic [31:0]       sum_len_reg, sum_len_next;
    logic              calc_reg, calc_next;
    logic [LOG_AW-1:0] log_wp_reg, log_wp_next;
    logic [LOG_AW-1:0] log_rp_reg, log_rp_next;
    logic              log_full_reg, log_full_next;

    logic [PAGE_BYTES-1:0] page_vld_reg;
    logic [SUM_BYTES-1:0]  sum_vld_reg;
    logic                  page_vq_reg, sum_vq_reg, log_vq_reg;

    // stage 1: memory data in flight
    logic        s1_valid_reg;
    logic        s1_flush_reg;
    rd_src_t     s1_rsel_reg;
    logic [7:0]  s1_rbyte_reg;
    logic        s1_page_reg;
    logic        s1_rst_reg;
    logic        s1_pend_reg;
    logic [31:0] s1_soff_reg;
    logic [31:0] s1_slen_reg;
    logic        s1_adv;

    // output word
    logic        out_valid_reg;
    logic [7:0]  rd_reg;
    logic        freq_reg;
    logic [31:0] faddr_reg;
    logic        rst_reg;
    logic        pend_reg;
    logic [31:0] soff_reg;
    logic [31:0] slen_reg;
    logic [7:0]  pb_reg;

    logic in_fire;

    // per-word decode
    rd_src_t    rsel;
    logic [7:0] rbyte;
    logic       page_hit;
    logic       rst_w;
    logic       mod_start;

    logic               page_we, page_re;
    logic [PAGE_AW-1:0] page_waddr, page_raddr;
    logic [7:0]         page_q;
    logic               sum_we, sum_re;
    logic [SUM_AW-1:0]  sum_waddr, sum_raddr;
    logic [7:0]         sum_q;
    logic               log_we, log_re;
    logic [7:0]         log_q;

    logic [31:0] mod_addr;

    logic [7:0] off_page, off_sum;
    logic       in_page_rng, in_sum_rng;

    assign off_page    = reg_index_reg - A_PAGE;
    assign off_sum     = reg_index_reg - A_SUM;
    assign in_page_rng = (reg_index_reg >= A_PAGE) && ({1'b0, reg_index_reg} < 9'(PAGE_END));
    assign in_sum_rng  = (reg_index_reg >= A_SUM) && ({1'b0, reg_index_reg} < 9'(SUM_END));

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    assign page_waddr = off_page[PAGE_AW-1:0];
    assign page_raddr = side_index[PAGE_AW-1:0];
    assign sum_waddr  = side_index[SUM_AW-1:0];
    assign sum_raddr  = off_sum[SUM_AW-1:0];

    always_comb
    begin
        reg_index_next   = reg_index_reg;
        idx_pend_next    = idx_pend_reg;
        flush_armed_next = flush_armed_reg;
        foff_next        = foff_reg;
        sum_off_next     = sum_off_reg;
        sum_len_next     = sum_len_reg;
        calc_next        = calc_reg;
        log_wp_next      = log_wp_reg;
        log_rp_next      = log_rp_reg;
        log_full_next    = log_full_reg;
        rsel             = RD_LOCAL;
        rbyte            = 8'd0;
        page_hit         = 1'b0;
        rst_w            = 1'b0;
        mod_start        = 1'b0;
        page_we          = 1'b0;
        page_re          = 1'b0;
        sum_we           = 1'b0;
        sum_re           = 1'b0;
        log_we           = 1'b0;
        log_re           = 1'b0;
        if (in_fire)
        begin
            case (operation)
                OP_START_WRITE:
                begin
                    idx_pend_next = 1'b1;
                end
                OP_WRITE_BYTE:
                begin
                    if (idx_pend_reg)
                    begin
                        reg_index_next = data_byte;
                        idx_pend_next  = 1'b0;
                    end
                    else
                    begin
                        reg_index_next = reg_index_reg + 8'd1;
                        if (reg_index_reg == A_TRIG)
                        begin
                            calc_next = 1'b1;
                        end
                        else if (reg_index_reg[7:2] == A_SOFF[7:2])
                        begin
                            sum_off_next = put_be(sum_off_reg, reg_index_reg[1:0], data_byte);
                        end
                        else if (reg_index_reg[7:2] == A_SLEN[7:2])
                        begin
                            sum_len_next = put_be(sum_len_reg, reg_index_reg[1:0], data_byte);
                        end
                        else if (reg_index_reg[7:2] == A_FOFF[7:2])
                        begin
                            foff_next = put_be(foff_reg, reg_index_reg[1:0], data_byte);
                        end
                        else if (in_page_rng)
                        begin
                            page_we = 1'b1;
                            if ({1'b0, reg_index_reg} == 9'(PAGE_END - 1))
                            begin
                                flush_armed_next = 1'b1;
                            end
                        end
                        else if (reg_index_reg == A_LOG)
                        begin
                            log_rp_next = log_wrap(data_byte);
                        end
                        else if (reg_index_reg == A_CMD)
                        begin
                            rst_w = (data_byte == CMD_RST_A) || (data_byte == CMD_RST_B)
                                    || (data_byte == CMD_RST_C);
                        end
                    end
                end
                OP_READ_BYTE:
                begin
                    reg_index_next = reg_index_reg + 8'd1;
                    if (reg_index_reg == A_STAGE)
                    begin
                        rbyte = STAGE_CODE;
                    end
                    else if (reg_index_reg == A_TRIG)
                    begin
                        rbyte = {7'd0, calc_reg};
                    end
                    else if (reg_index_reg[7:2] == A_SOFF[7:2])
                    begin
                        rbyte = get_be(sum_off_reg, reg_index_reg[1:0]);
                    end
                    else if (reg_index_reg[7:2] == A_SLEN[7:2])
                    begin
                        rbyte = get_be(sum_len_reg, reg_index_reg[1:0]);
                    end
                    else if (in_sum_rng)
                    begin
                        rsel   = RD_SUM;
                        sum_re = 1'b1;
                    end
                    else if (in_page_rng)
                    begin
                        rbyte = flash_byte;
                    end
                    else if (reg_index_reg[7:2] == A_FOFF[7:2])
                    begin
                        rbyte = get_be(foff_reg, reg_index_reg[1:0]);
                    end
                    else if (reg_index_reg == A_LOG)
                    begin
                        rsel        = RD_LOG;
                        log_re      = 1'b1;
                        log_rp_next = log_inc(log_rp_reg);
                    end
                end
                OP_STOP:
                begin
                    if (flush_armed_reg)
                    begin
                        mod_start        = 1'b1;
                        flush_armed_next = 1'b0;
                    end
                end
                OP_LOG_CHAR:
                begin
                    log_we      = 1'b1;
                    log_wp_next = log_inc(log_wp_reg);
                    if (log_wp_reg == LOG_AW'(LOG_DEPTH - 1))
                    begin
                        log_full_next = 1'b1;
                    end
                end
                OP_SUM_BYTE:
                begin
                    sum_we = ({1'b0, side_index} < 8'(SUM_BYTES));
                end
                OP_SUM_DONE:
                begin
                    calc_next = 1'b0;
                end
                OP_PAGE_READ:
                begin
                    page_hit = ({1'b0, side_index} < 8'(PAGE_BYTES));
                    page_re  = page_hit;
                end
                default:
                begin
                end
            endcase
        end
    end

    i2curm_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (page_waddr),
        .wdata (data_byte),
        .re    (page_re),
        .raddr (page_raddr),
        .rdata (page_q)
    );

    i2curm_ram #(.WIDTH(8), .DEPTH(SUM_BYTES)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (data_byte),
        .re    (sum_re),
        .raddr (sum_raddr),
        .rdata (sum_q)
    );

    i2curm_ram #(.WIDTH(8), .DEPTH(LOG_DEPTH)) u_log_ram (
        .clk   (clk),
        .we    (log_we),
        .waddr (log_wp_reg),
        .wdata (data_byte),
        .re    (log_re),
        .raddr (log_rp_reg),
        .rdata (log_q)
    );

    // flash offset is stable from the stop until its word leaves stage 1
    i2curm_pgmod #(.DIVISOR(PAGE_BYTES)) u_pgmod (
        .value (foff_reg),
        .addr  (mod_addr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_index_reg   <= '0;
            idx_pend_reg    <= 1'b0;
            flush_armed_reg <= 1'b0;
            foff_reg        <= '0;
            sum_off_reg     <= '0;
            sum_len_reg     <= '0;
            calc_reg        <= 1'b0;
            log_wp_reg      <= '0;
            log_rp_reg      <= '0;
            log_full_reg    <= 1'b0;
            page_vld_reg    <= '0;
            sum_vld_reg     <= '0;
            s1_valid_reg    <= 1'b0;
            s1_flush_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            reg_index_reg   <= reg_index_next;
            idx_pend_reg    <= idx_pend_next;
            flush_armed_reg <= flush_armed_next;
            foff_reg        <= foff_next;
            sum_off_reg     <= sum_off_next;
            sum_len_reg     <= sum_len_next;
            calc_reg        <= calc_next;
            log_wp_reg      <= log_wp_next;
            log_rp_reg      <= log_rp_next;
            log_full_reg    <= log_full_next;
            if (page_we)
            begin
                page_vld_reg[page_waddr] <= 1'b1;
            end
            if (sum_we)
            begin
                sum_vld_reg[sum_waddr] <= 1'b1;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                s1_flush_reg <= mod_start;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
                s1_flush_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (page_re)
        begin
            page_vq_reg <= page_vld_reg[page_raddr];
        end
        if (sum_re)
        begin
            sum_vq_reg <= sum_vld_reg[sum_raddr];
        end
        if (log_re)
        begin
            log_vq_reg <= log_full_reg || (log_rp_reg < log_wp_reg);
        end
        if (in_fire)
        begin
            s1_rsel_reg  <= rsel;
            s1_rbyte_reg <= rbyte;
            s1_page_reg  <= page_hit;
            s1_rst_reg   <= rst_w;
            s1_pend_reg  <= calc_next;
            s1_soff_reg  <= sum_off_next;
            s1_slen_reg  <= sum_len_next;
        end
        if (s1_adv)
        begin
            case (s1_rsel_reg)
                RD_SUM:  rd_reg <= sum_vq_reg ? sum_q : 8'd0;
                RD_LOG:  rd_reg <= log_vq_reg ? log_q : 8'd0;
                default: rd_reg <= s1_rbyte_reg;
            endcase
            freq_reg  <= s1_flush_reg;
            faddr_reg <= s1_flush_reg ? mod_addr : 32'd0;
            rst_reg   <= s1_rst_reg;
            pend_reg  <= s1_pend_reg;
            soff_reg  <= s1_soff_reg;
            slen_reg  <= s1_slen_reg;
            pb_reg    <= (s1_page_reg && page_vq_reg) ? page_q : 8'd0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign read_data        = rd_reg;
    assign flush_request    = freq_reg;
    assign flush_address    = faddr_reg;
    assign reset_request    = rst_reg;
    assign checksum_pending = pend_reg;
    assign checksum_offset  = soff_reg;
    assign checksum_length  = slen_reg;
    assign page_byte        = pb_reg;

    a_flush_disarm: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && operation == OP_STOP) |=> !flush_armed_reg)
        else $error("flush still armed after stop");

    a_index_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && operation == OP_WRITE_BYTE && idx_pend_reg)
        |=> (!idx_pend_reg && reg_index_reg == $past(data_byte)))
        else $error("register index not loaded by first written word");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready)
        |=> (out_valid_reg && $stable(rd_reg) && $stable(faddr_reg) && $stable(soff_reg)
             && $stable(slen_reg) && $stable(pb_reg)))
        else $error("result word changed while waiting");

    a_flush_align: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((faddr_reg & 32'(PAGE_BYTES - 1)) == 32'd0))
        else $error("flush address not page aligned");

endmodule

// File: sim/i2c_regmap_check.sv
`timescale 1ns / 1ps

module i2c_regmap_check #(
    parameter int PAGE_BYTES = 128,
    parameter int LOG_DEPTH  = 256,
    parameter int SUM_BYTES  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [3:0]  operation,
    input  logic [7:0]  data_byte,
    input  logic [6:0]  side_index,
    input  logic [7:0]  flash_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  read_data,
    input  logic        flush_request,
    input  logic [31:0] flush_address,
    input  logic        reset_request,
    input  logic        checksum_pending,
    input  logic [31:0] checksum_offset,
    input  logic [31:0] checksum_length,
    input  logic [7:0]  page_byte,
    output int          failures,
    output int          outstanding
);
    import i2curm_pkg::*;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        flush_request;
        logic [31:0] flush_address;
        logic        reset_request;
        logic        checksum_pending;
        logic [31:0] checksum_offset;
        logic [31:0] checksum_length;
        logic [7:0]  page_byte;
    } map_word_t;

    logic [7:0]  reg_idx;
    logic        idx_pending;
    logic        flush_armed;
    logic        calc_flag;
    logic [31:0] foff;
    logic [31:0] sum_off;
    logic [31:0] sum_len;
    logic [7:0]  sum_mem [SUM_BYTES];
    logic [7:0]  page_mem [PAGE_BYTES];
    logic [7:0]  log_mem [LOG_DEPTH];
    logic [7:0]  log_wr;
    logic [7:0]  log_rd;

    map_word_t   regmap_due [$];
    map_word_t   exp_w;

    function automatic map_word_t regmap_step(input logic [3:0] op, input logic [7:0] d,
                                              input logic [6:0] side, input logic [7:0] fb);
        map_word_t w;
        int        idx;
        int        lane;
        w = '0;
        idx = int'(reg_idx);
        lane = (3 - int'(reg_idx[1:0])) * 8;
        case (op)
            OP_START_WRITE: idx_pending = 1'b1;
            OP_WRITE_BYTE:
            begin
                if (idx_pending)
                begin
                    reg_idx = d;
                    idx_pending = 1'b0;
                end
                else
                begin
                    if (reg_idx == A_TRIG)
                        calc_flag = 1'b1;
                    else if (reg_idx[7:2] == A_SOFF[7:2])
                        sum_off[lane +: 8] = d;
                    else if (reg_idx[7:2] == A_SLEN[7:2])
                        sum_len[lane +: 8] = d;
                    else if (reg_idx[7:2] == A_FOFF[7:2])
                        foff[lane +: 8] = d;
                    else if (idx >= int'(A_PAGE) && idx < int'(A_PAGE) + PAGE_BYTES)
                    begin
                        page_mem[idx - int'(A_PAGE)] = d;
                        if (idx == int'(A_PAGE) + PAGE_BYTES - 1)
                            flush_armed = 1'b1;
                    end
                    else if (reg_idx == A_LOG)
                        log_rd = 8'(int'(d) % LOG_DEPTH);
                    else if (reg_idx == A_CMD)
                        w.reset_request = (d == CMD_RST_A || d == CMD_RST_B || d == CMD_RST_C);
                    reg_idx = reg_idx + 8'd1;
                end
            end
            OP_READ_BYTE:
            begin
                if (reg_idx == A_STAGE)
                    w.read_data = STAGE_CODE;
                else if (reg_idx == A_TRIG)
                    w.read_data = {7'd0, calc_flag};
                else if (reg_idx[7:2] == A_SOFF[7:2])
                    w.read_data = sum_off[lane +: 8];
                else if (reg_idx[7:2] == A_SLEN[7:2])
                    w.read_data = sum_len[lane +: 8];
                else if (idx >= int'(A_SUM) && idx < int'(A_SUM) + SUM_BYTES)
                    w.read_data = sum_mem[idx - int'(A_SUM)];
                else if (idx >= int'(A_PAGE) && idx < int'(A_PAGE) + PAGE_BYTES)
                    w.read_data = fb;
                else if (reg_idx[7:2] == A_FOFF[7:2])
                    w.read_data = foff[lane +: 8];
                else if (reg_idx == A_LOG)
                begin
                    w.read_data = log_mem[log_rd];
                    log_rd = 8'((int'(log_rd) + 1) % LOG_DEPTH);
                end
                reg_idx = reg_idx + 8'd1;
            end
            OP_STOP:
            begin
                if (flush_armed)
                begin
                    w.flush_request = 1'b1;
                    w.flush_address = foff - (foff % 32'(PAGE_BYTES));
                    flush_armed = 1'b0;
                end
            end
            OP_LOG_CHAR:
            begin
                log_mem[log_wr] = d;
                log_wr = 8'((int'(log_wr) + 1) % LOG_DEPTH);
            end
            OP_SUM_BYTE:
            begin
                if (int'(side) < SUM_BYTES)
                    sum_mem[side] = d;
            end
            OP_SUM_DONE: calc_flag = 1'b0;
            OP_PAGE_READ:
            begin
                if (int'(side) < PAGE_BYTES)
                    w.page_byte = page_mem[side];
            end
            default: ;
        endcase
        w.checksum_pending = calc_flag;
        w.checksum_offset = sum_off;
        w.checksum_length = sum_len;
        return w;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_idx = '0;
            idx_pending = 1'b0;
            flush_armed = 1'b0;
            calc_flag = 1'b0;
            foff = '0;
            sum_off = '0;
            sum_len = '0;
            log_wr = '0;
            log_rd = '0;
            for (int k = 0; k < SUM_BYTES; k++)
                sum_mem[k] = '0;
            for (int k = 0; k < PAGE_BYTES; k++)
                page_mem[k] = '0;
            for (int k = 0; k < LOG_DEPTH; k++)
                log_mem[k] = '0;
            regmap_due.delete();
            failures = 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (regmap_due.size() == 0)
                begin
                    $error("result word with nothing expected");
                    failures++;
                end
                else
                begin
                    exp_w = regmap_due.pop_front();
                    check_field("read_data", exp_w.read_data, read_data);
                    check_field("flush_request", exp_w.flush_request, flush_request);
                    check_field("flush_address", exp_w.flush_address, flush_address);
                    check_field("reset_request", exp_w.reset_request, reset_request);
                    check_field("checksum_pending", exp_w.checksum_pending, checksum_pending);
                    check_field("checksum_offset", exp_w.checksum_offset, checksum_offset);
                    check_field("checksum_length", exp_w.checksum_length, checksum_length);
                    check_field("page_byte", exp_w.page_byte, page_byte);
                end
            end
            if (in_valid && in_ready)
                regmap_due.push_back(regmap_step(operation, data_byte, side_index, flash_byte));
            outstanding <= regmap_due.size();
        end
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import i2curm_pkg::*;

    localparam int PAGE_BYTES = 128;
    localparam int LOG_DEPTH  = 256;
    localparam int SUM_BYTES  = 16;
    localparam int RANDOM_WORDS = 1600;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  operation;
    logic [7:0]  data_byte;
    logic [6:0]  side_index;
    logic [7:0]  flash_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_data;
    logic        flush_request;
    logic [31:0] flush_address;
    logic        reset_request;
    logic        checksum_pending;
    logic [31:0] checksum_offset;
    logic [31:0] checksum_length;
    logic [7:0]  page_byte;

    int failures;
    int outstanding;
    int words_sent;
    int cycle_count;
    bit quiet;
    bit mid_drained;

    i2c_upgrade_register_map_core #(
        .PAGE_BYTES(PAGE_BYTES),
        .LOG_DEPTH(LOG_DEPTH),
        .SUM_BYTES(SUM_BYTES)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .data_byte(data_byte),
        .side_index(side_index),
        .flash_byte(flash_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .read_data(read_data),
        .flush_request(flush_request),
        .flush_address(flush_address),
        .reset_request(reset_request),
        .checksum_pending(checksum_pending),
        .checksum_offset(checksum_offset),
        .checksum_length(checksum_length),
        .page_byte(page_byte)
    );

    i2c_regmap_check #(
        .PAGE_BYTES(PAGE_BYTES),
        .LOG_DEPTH(LOG_DEPTH),
        .SUM_BYTES(SUM_BYTES)
    ) i_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .data_byte(data_byte),
        .side_index(side_index),
        .flash_byte(flash_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .read_data(read_data),
        .flush_request(flush_request),
        .flush_address(flush_address),
        .reset_request(reset_request),
        .checksum_pending(checksum_pending),
        .checksum_offset(checksum_offset),
        .checksum_length(checksum_length),
        .page_byte(page_byte),
        .failures(failures),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= quiet || ($urandom_range(0, 99) >= 23);
    end

    // one word per call; the payload holds until accepted
    task automatic send_word(input logic [3:0] op, input logic [7:0] d, input logic [6:0] side);
        operation <= op;
        data_byte <= d;
        side_index <= side;
        flash_byte <= 8'($urandom_range(0, 255));
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        quiet = (words_sent >= 700 && words_sent < 1000);
        if (!quiet)
        begin
            while ($urandom_range(0, 99) < 23)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [6:0] rand_side();
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] pick_index();
        case ($urandom_range(0, 11))
            0: return A_CMD;
            1: return A_STAGE;
            2: return A_LOG;
            3: return A_TRIG;
            4: return 8'(A_SOFF + $urandom_range(0, 3));
            5: return 8'(A_SLEN + $urandom_range(0, 3));
            6: return 8'(A_SUM + $urandom_range(0, SUM_BYTES - 1));
            7: return 8'(A_FOFF + $urandom_range(0, 3));
            8: return 8'(A_PAGE + $urandom_range(0, PAGE_BYTES - 1));
            9: return 8'(8'hff - $urandom_range(0, 7));
            default: return rand_byte();
        endcase
    endfunction

    task automatic write_burst(input logic [7:0] idx, input int n);
        logic [7:0] d;
        send_word(OP_START_WRITE, rand_byte(), rand_side());
        send_word(OP_WRITE_BYTE, idx, rand_side());
        repeat (n)
        begin
            case ($urandom_range(0, 5))
                0: d = CMD_RST_A;
                1: d = CMD_RST_B;
                2: d = CMD_RST_C;
                default: d = rand_byte();
            endcase
            send_word(OP_WRITE_BYTE, d, rand_side());
        end
        if ($urandom_range(0, 4) != 0)
            send_word(OP_STOP, rand_byte(), rand_side());
    endtask

    task automatic read_burst(input logic [7:0] idx, input int n);
        send_word(OP_START_WRITE, rand_byte(), rand_side());
        send_word(OP_WRITE_BYTE, idx, rand_side());
        send_word(OP_START_READ, rand_byte(), rand_side());
        repeat (n)
            send_word(OP_READ_BYTE, rand_byte(), rand_side());
        if ($urandom_range(0, 4) != 0)
            send_word(OP_STOP, rand_byte(), rand_side());
    endtask

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_START_READ;
        data_byte = '0;
        side_index = '0;
        flash_byte = '0;
        words_sent = 0;
        quiet = 1'b0;
        mid_drained = 1'b0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stage code through a read start
        send_word(OP_START_WRITE, 8'h00, 7'd0);
        send_word(OP_WRITE_BYTE, A_STAGE, 7'd0);
        send_word(OP_START_READ, 8'h00, 7'd0);
        send_word(OP_READ_BYTE, 8'hff, 7'd127);
        // big-endian checksum offset, byte extremes
        send_word(OP_START_WRITE, 8'hff, 7'd127);
        send_word(OP_WRITE_BYTE, A_SOFF, 7'd0);
        send_word(OP_WRITE_BYTE, 8'hff, 7'd0);
        send_word(OP_WRITE_BYTE, 8'h00, 7'd0);
        send_word(OP_WRITE_BYTE, 8'hff, 7'd0);
        send_word(OP_WRITE_BYTE, 8'h00, 7'd0);
        // trigger with zero data still sets the flag
        send_word(OP_START_WRITE, 8'h00, 7'd0);
        send_word(OP_WRITE_BYTE, A_TRIG, 7'd0);
        send_word(OP_WRITE_BYTE, 8'h00, 7'd0);
        send_word(OP_SUM_DONE, 8'h00, 7'd0);
        send_word(OP_SUM_BYTE, 8'hff, 7'(SUM_BYTES - 1));
        send_word(OP_SUM_BYTE, 8'h5a, 7'd127);
        send_word(OP_LOG_CHAR, 8'hab, 7'd0);
        send_word(OP_PAGE_READ, 8'h00, 7'd127);
        send_word(OP_START_WRITE, 8'h00, 7'd0);
        send_word(OP_WRITE_BYTE, A_CMD, 7'd0);
        send_word(OP_WRITE_BYTE, CMD_RST_C, 7'd0);
        // last page byte arms the flush, index wraps to zero
        send_word(OP_START_WRITE, 8'h00, 7'd0);
        send_word(OP_WRITE_BYTE, 8'hff, 7'd0);
        send_word(OP_WRITE_BYTE, 8'h55, 7'd0);
        send_word(OP_STOP, 8'h00, 7'd0);
        send_word(4'd15, 8'hff, 7'd127);
        wait_drained();

        while (words_sent < RANDOM_WORDS + 26)
        begin
            if (!mid_drained && words_sent >= 400)
            begin
                wait_drained();
                mid_drained = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: write_burst(pick_index(), $urandom_range(1, 8));
                4, 5, 6: read_burst(pick_index(), $urandom_range(1, 8));
                7, 8:
                begin
                    case ($urandom_range(0, 3))
                        0: send_word(OP_LOG_CHAR, rand_byte(), rand_side());
                        1: send_word(OP_SUM_BYTE, rand_byte(),
                                     $urandom_range(0, 1) ? 7'($urandom_range(0, SUM_BYTES - 1))
                                                          : rand_side());
                        2: send_word(OP_SUM_DONE, rand_byte(), rand_side());
                        default: send_word(OP_PAGE_READ, rand_byte(), rand_side());
                    endcase
                end
                default: send_word(4'($urandom_range(0, 15)), rand_byte(), rand_side());
            endcase
        end

        wait_drained();
        repeat (20)
            @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
